[hw/rtl/dsnt_pkg.sv]
// Shared types, codes and constants of the distance-sorted neighbor table.
`default_nettype none

package dsnt_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 16;

    // Stream widths: request and result fields packed from bit 0 up, padded to bytes.
    localparam int IN_W    = 72;
    localparam int OUT_W   = 80;
    localparam int OUT_PAD = OUT_W - 76;
    localparam int IN_PAD  = IN_W - 70;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_INSERTED  = 3'd0;
    localparam logic [2:0] STAT_UPDATED   = 3'd1;
    localparam logic [2:0] STAT_OK        = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;

    // One stored entry, address in the low bits.
    typedef struct packed {
        logic signed [15:0] eff;
        logic signed [15:0] snr;
        logic signed [15:0] distance;
        logic [15:0]        addr;
    } entry_t;

    // Kind of walk over the entry memory.
    typedef enum logic [1:0] {
        WALK_FIND,
        WALK_DEL,
        WALK_LOC,
        WALK_INS
    } walk_t;

    // Which result the output register is loaded with.
    typedef enum logic [2:0] {
        RES_MISS,
        RES_ABSENT,
        RES_FULL,
        RES_FOUND,
        RES_NEW,
        RES_READ
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  take_req;
        logic  run;
        walk_t walk;
        logic  start_del;
        logic  start_loc;
        logic  start_ins;
        logic  dec_count;
        logic  write_new;
        logic  read_pos;
        logic  load_out;
        res_t  res;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       walk_done;
        logic       walk_hit;
        logic [1:0] op;
        logic       present;
        logic       full;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

[hw/rtl/dsnt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dsnt_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/dsnt_ctrl.sv]
// Controller state machine that sequences the table walks for each request.
`default_nettype none

module dsnt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  dsnt_pkg::sts_t sts,
    output dsnt_pkg::cmd_t cmd
);

    import dsnt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_DEL,
        S_LOC,
        S_INS,
        S_WRITE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.walk   = WALK_FIND;
        cmd.res    = res_reg;
        s_tready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                unique case (sts.op) inside
                    OP_INSERT, OP_REMOVE:
                    begin
                        state_next = S_FIND;
                    end
                    OP_READ:
                    begin
                        if (sts.present)
                        begin
                            cmd.read_pos = 1'b1;
                            res_next     = RES_READ;
                        end
                        else
                        begin
                            res_next = RES_MISS;
                        end
                        state_next = S_FINISH;
                    end
                    default:
                    begin
                        res_next   = RES_MISS;
                        state_next = S_FINISH;
                    end
                endcase
            end

            S_FIND:
            begin
                cmd.run  = 1'b1;
                cmd.walk = WALK_FIND;
                if (sts.walk_done)
                begin
                    if (sts.walk_hit)
                    begin
                        // Both a remove and an update first close the gap.
                        cmd.start_del = 1'b1;
                        state_next    = S_DEL;
                    end
                    else if (sts.op == OP_REMOVE)
                    begin
                        res_next   = RES_ABSENT;
                        state_next = S_FINISH;
                    end
                    else if (sts.full)
                    begin
                        res_next   = RES_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.start_loc = 1'b1;
                        state_next    = S_LOC;
                    end
                end
            end

            S_DEL:
            begin
                cmd.run  = 1'b1;
                cmd.walk = WALK_DEL;
                if (sts.walk_done)
                begin
                    cmd.dec_count = 1'b1;
                    if (sts.op == OP_REMOVE)
                    begin
                        res_next   = RES_FOUND;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.start_loc = 1'b1;
                        state_next    = S_LOC;
                    end
                end
            end

            S_LOC:
            begin
                cmd.run  = 1'b1;
                cmd.walk = WALK_LOC;
                if (sts.walk_done)
                begin
                    cmd.start_ins = 1'b1;
                    state_next    = S_INS;
                end
            end

            S_INS:
            begin
                cmd.run  = 1'b1;
                cmd.walk = WALK_INS;
                if (sts.walk_done)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                cmd.write_new = 1'b1;
                res_next      = RES_NEW;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_MISS;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dsnt_dpath.sv]
// Datapath: entry memory, walk pointer, compare stage, count and result register.
`default_nettype none

module dsnt_dpath #(
    parameter int  TABLE_DEPTH = dsnt_pkg::TABLE_DEPTH_DEF,
    localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dsnt_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dsnt_pkg::OUT_W-1:0] m_tdata,
    input  dsnt_pkg::cmd_t             cmd,
    output dsnt_pkg::sts_t             sts
);

    import dsnt_pkg::*;

    // Control registers.
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic          chk_vld_reg, chk_vld_next;
    logic          found_reg, found_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic [AW-1:0]      chk_idx_reg, chk_idx_next;
    logic [AW-1:0]      found_pos_reg, found_pos_next;
    logic [CW-1:0]      ins_pos_reg, ins_pos_next;
    entry_t             cap_reg, cap_next;
    logic [1:0]         req_op_reg;
    logic [15:0]        req_addr_reg;
    logic signed [15:0] req_dist_reg;
    logic signed [15:0] req_snr_reg;
    logic signed [15:0] req_eff_reg;
    logic [3:0]         req_pos_reg;
    logic [2:0]         out_status_reg, out_status_next;
    entry_t             out_entry_reg, out_entry_next;
    logic [3:0]         out_pos_reg, out_pos_next;
    logic [4:0]         out_count_reg, out_count_next;

    // Memory ports and walk logic.
    entry_t        rd_entry;
    entry_t        wr_entry;
    entry_t        new_entry;
    logic          we;
    logic          re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [AW-1:0] rd_idx;
    logic [CW-1:0] rp_dec;
    logic          issue;
    logic          hit;
    logic          walk_done;

    dsnt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    always_comb
    begin
        new_entry.addr     = req_addr_reg;
        new_entry.distance = req_dist_reg;
        new_entry.snr      = found_reg ? cap_reg.snr : req_snr_reg;
        new_entry.eff      = found_reg ? cap_reg.eff : req_eff_reg;
    end

    // Walk pointer: ascending for find, locate and delete, descending for the
    // insertion shift. The compare stage sees the entry read in the cycle before.
    always_comb
    begin
        rp_dec = rp_reg - 1'b1;
        if (cmd.walk == WALK_INS)
        begin
            issue  = rp_reg > ins_pos_reg;
            rd_idx = rp_dec[AW-1:0];
        end
        else
        begin
            issue  = rp_reg < count_reg;
            rd_idx = rp_reg[AW-1:0];
        end

        hit = 1'b0;
        if (chk_vld_reg)
        begin
            case (cmd.walk)
                WALK_FIND: hit = (rd_entry.addr == req_addr_reg);
                WALK_LOC:  hit = ($signed(rd_entry.distance) > $signed(req_dist_reg));
                default:   hit = 1'b0;
            endcase
        end

        walk_done = hit || (!chk_vld_reg && !issue);
    end

    always_comb
    begin
        re    = (cmd.run && issue) || cmd.read_pos;
        raddr = cmd.read_pos ? AW'(req_pos_reg) : rd_idx;

        we       = 1'b0;
        waddr    = chk_idx_reg;
        wr_entry = rd_entry;
        if (cmd.write_new)
        begin
            we       = 1'b1;
            waddr    = ins_pos_reg[AW-1:0];
            wr_entry = new_entry;
        end
        else if (cmd.run && chk_vld_reg)
        begin
            case (cmd.walk)
                WALK_DEL:
                begin
                    we    = 1'b1;
                    waddr = chk_idx_reg - 1'b1;
                end
                WALK_INS:
                begin
                    we    = 1'b1;
                    waddr = chk_idx_reg + 1'b1;
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        rp_next        = rp_reg;
        chk_vld_next   = chk_vld_reg;
        chk_idx_next   = chk_idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        found_pos_next = found_pos_reg;
        cap_next       = cap_reg;
        ins_pos_next   = ins_pos_reg;

        if (cmd.run)
        begin
            chk_vld_next = issue;
            if (issue)
            begin
                chk_idx_next = rd_idx;
                rp_next      = (cmd.walk == WALK_INS) ? rp_dec : rp_reg + 1'b1;
            end
            if (cmd.walk == WALK_FIND && hit)
            begin
                found_next     = 1'b1;
                found_pos_next = chk_idx_reg;
                cap_next       = rd_entry;
            end
            if (cmd.walk == WALK_LOC && walk_done)
            begin
                ins_pos_next = hit ? CW'(chk_idx_reg) : count_reg;
            end
        end

        if (cmd.take_req || cmd.start_loc)
        begin
            rp_next      = '0;
            chk_vld_next = 1'b0;
        end
        if (cmd.start_del)
        begin
            rp_next      = CW'(chk_idx_reg) + 1'b1;
            chk_vld_next = 1'b0;
        end
        if (cmd.start_ins)
        begin
            rp_next      = count_reg;
            chk_vld_next = 1'b0;
        end
        if (cmd.take_req)
        begin
            found_next = 1'b0;
        end

        if (cmd.dec_count)
        begin
            count_next = count_reg - 1'b1;
        end
        else if (cmd.write_new)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Result register.
    always_comb
    begin
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            out_count_next  = 5'(count_reg);
            out_entry_next  = '0;
            out_pos_next    = '0;
            out_status_next = STAT_NOT_FOUND;
            case (cmd.res)
                RES_ABSENT:
                begin
                    out_entry_next.addr = req_addr_reg;
                end
                RES_FULL:
                begin
                    out_status_next     = STAT_FULL;
                    out_entry_next.addr = req_addr_reg;
                end
                RES_FOUND:
                begin
                    out_status_next = STAT_OK;
                    out_entry_next  = cap_reg;
                    out_pos_next    = 4'(found_pos_reg);
                end
                RES_NEW:
                begin
                    out_status_next = found_reg ? STAT_UPDATED : STAT_INSERTED;
                    out_entry_next  = new_entry;
                    out_pos_next    = 4'(ins_pos_reg);
                end
                RES_READ:
                begin
                    out_status_next = STAT_OK;
                    out_entry_next  = rd_entry;
                    out_pos_next    = req_pos_reg;
                end
                default:
                begin
                    out_status_next = STAT_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rp_reg        <= '0;
            chk_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rp_reg        <= rp_next;
            chk_vld_reg   <= chk_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        found_pos_reg  <= found_pos_next;
        ins_pos_reg    <= ins_pos_next;
        cap_reg        <= cap_next;
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
        if (cmd.take_req)
        begin
            req_op_reg   <= s_tdata[1:0];
            req_addr_reg <= s_tdata[17:2];
            req_dist_reg <= s_tdata[33:18];
            req_snr_reg  <= s_tdata[49:34];
            req_eff_reg  <= s_tdata[65:50];
            req_pos_reg  <= s_tdata[69:66];
        end
    end

    assign sts.walk_done = walk_done;
    assign sts.walk_hit  = hit;
    assign sts.op        = req_op_reg;
    assign sts.present   = 32'(req_pos_reg) < 32'(count_reg);
    assign sts.full      = count_reg >= CW'(TABLE_DEPTH);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_count_reg, out_pos_reg, out_entry_reg,
                       out_status_reg};

    a_write_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> count_reg < CW'(TABLE_DEPTH))
        else $error("new entry written into a full table");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("entry count did not grow after a write");

    a_del_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_count |-> count_reg != '0)
        else $error("entry count decremented below zero");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

[hw/rtl/distance_sorted_neighbor_table_top.sv]
// Top level of the distance-sorted neighbor table.
`default_nettype none

// The block keeps up to TABLE_DEPTH neighbor entries in a single-port-write
// RAM, ordered by rising signed distance, and serves one request at a time:
// insert-or-update, remove by address, or read by position; every request
// yields exactly one result. All work is done by walks through the entry RAM
// that touch one entry per clock cycle, so the time per request follows the
// number of valid entries N. A read or an unused operation code needs no walk.
// A remove runs a search to the matching address and a shift that closes the
// gap. An insert runs a search, a locate, a shift up and a write, and an
// update the same steps, since its search stops at the entry, the gap is
// closed from there, and the entry is then inserted again at its new place.
// A new request is accepted as soon as the previous result sits in the output
// register, even if that result has not yet been taken. The entry RAM needs no
// clearing after reset; only positions below the entry count are ever read.
module distance_sorted_neighbor_table_top #(
    parameter int TABLE_DEPTH = dsnt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Request: op[1:0], neighbor_addr[17:2], distance[33:18], avg_snr[49:34],
    // effective_distance[65:50], position[69:66], zero padding[71:70].
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [dsnt_pkg::IN_W-1:0]  s_tdata,
    // Result: status[2:0], entry_addr[18:3], entry_distance[34:19],
    // entry_avg_snr[50:35], entry_eff_distance[66:51], entry_position[70:67],
    // entry_count[75:71], zero padding[79:76].
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [dsnt_pkg::OUT_W-1:0] m_tdata
);

    import dsnt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller decides which walk runs next; the datapath owns the RAM,
    // the walk pointer, the entry count and the result register.
    dsnt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dsnt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

[dv/dsnt_tb_pkg.sv]
// Request and result layouts and the scoreboard class for the neighbor table testbench.
`timescale 1ns / 1ps

package dsnt_tb_pkg;

    import dsnt_pkg::*;

    // Operation code that the block has no meaning for.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [IN_PAD-1:0]  pad;
        logic [3:0]         position;
        logic signed [15:0] eff;
        logic signed [15:0] snr;
        logic signed [15:0] distance;
        logic [15:0]        addr;
        logic [1:0]         op;
    } request_t;

    typedef struct packed {
        logic [OUT_PAD-1:0] pad;
        logic [4:0]         count;
        logic [3:0]         position;
        logic signed [15:0] eff;
        logic signed [15:0] snr;
        logic signed [15:0] distance;
        logic [15:0]        addr;
        logic [2:0]         status;
    } result_t;

    typedef struct packed {
        logic signed [15:0] eff;
        logic signed [15:0] snr;
        logic signed [15:0] distance;
        logic [15:0]        addr;
    } neighbor_t;

    // Mirrors the sorted table and queues the result each request should produce.
    class neighbor_scoreboard;
        neighbor_t table_mem[TABLE_DEPTH_DEF];
        int        entry_total;
        result_t   pending_results[$];
        int        error_count;
        int        request_count;
        int        status_seen[5];

        function new();
            entry_total   = 0;
            error_count   = 0;
            request_count = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function int find_addr(logic [15:0] addr);
            for (int i = 0; i < entry_total; i++)
                if (table_mem[i].addr == addr)
                    return i;
            return entry_total;
        endfunction

        function void remove_at(int p);
            for (int i = p; i < entry_total - 1; i++)
                table_mem[i] = table_mem[i + 1];
            entry_total--;
        endfunction

        // New entries go behind every entry of equal or smaller distance.
        function int place_entry(neighbor_t e);
            int p;
            p = 0;
            while (p < entry_total && $signed(table_mem[p].distance) <= $signed(e.distance))
                p++;
            for (int i = entry_total; i > p; i--)
                table_mem[i] = table_mem[i - 1];
            table_mem[p] = e;
            entry_total++;
            return p;
        endfunction

        function result_t entry_result(logic [2:0] status, int p);
            result_t res;
            res          = '0;
            res.status   = status;
            res.addr     = table_mem[p].addr;
            res.distance = table_mem[p].distance;
            res.snr      = table_mem[p].snr;
            res.eff      = table_mem[p].eff;
            res.position = 4'(p);
            return res;
        endfunction

        function void note_request(request_t r);
            result_t   res;
            neighbor_t e;
            int        p;
            res        = '0;
            res.status = STAT_NOT_FOUND;
            request_count++;
            case (r.op)
                OP_INSERT:
                begin
                    p = find_addr(r.addr);
                    if (p < entry_total)
                    begin
                        // An update keeps the stored SNR and effective distance.
                        e          = table_mem[p];
                        e.distance = r.distance;
                        remove_at(p);
                        p   = place_entry(e);
                        res = entry_result(STAT_UPDATED, p);
                    end
                    else if (entry_total >= TABLE_DEPTH_DEF)
                    begin
                        res.status = STAT_FULL;
                        res.addr   = r.addr;
                    end
                    else
                    begin
                        e.addr     = r.addr;
                        e.distance = r.distance;
                        e.snr      = r.snr;
                        e.eff      = r.eff;
                        p   = place_entry(e);
                        res = entry_result(STAT_INSERTED, p);
                    end
                end
                OP_REMOVE:
                begin
                    p = find_addr(r.addr);
                    if (p < entry_total)
                    begin
                        res = entry_result(STAT_OK, p);
                        remove_at(p);
                    end
                    else
                        res.addr = r.addr;
                end
                OP_READ:
                begin
                    if (r.position < entry_total)
                        res = entry_result(STAT_OK, r.position);
                end
                default:
                    ;
            endcase
            res.count = 5'(entry_total);
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, int want_v, int got_v);
            if (want_v != got_v)
            begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                error_count++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] raw);
            result_t got;
            result_t want;
            got = result_t'(raw);
            if (pending_results.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", raw);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (want.status <= STAT_FULL)
                status_seen[want.status]++;
            compare_field("status", want.status, got.status);
            compare_field("entry_addr", want.addr, got.addr);
            compare_field("entry_distance", $signed(want.distance), $signed(got.distance));
            compare_field("entry_avg_snr", $signed(want.snr), $signed(got.snr));
            compare_field("entry_eff_distance", $signed(want.eff), $signed(got.eff));
            compare_field("entry_position", want.position, got.position);
            compare_field("entry_count", want.count, got.count);
        endfunction
    endclass

endpackage

[dv/distance_sorted_neighbor_table_top_tb.sv]
// Top-level testbench of the distance-sorted neighbor table.
`timescale 1ns / 1ps

module distance_sorted_neighbor_table_top_tb;

    import dsnt_pkg::*;
    import dsnt_tb_pkg::*;

    // Stimulus size and shape.
    localparam int RANDOM_ITEMS = 1175;
    localparam int QUIET_TAIL   = 150;
    localparam int ADDR_POOL    = 24;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_CYCLES = 100;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    neighbor_scoreboard board;

    // A pool somewhat larger than the table, so that most removes hit and the
    // table regularly runs full during insert-heavy phases.
    logic [15:0] addr_pool[ADDR_POOL];

    // Random gaps on both sides are enabled only while this is set.
    bit traffic_gaps = 1'b1;
    // Raised once by the stimulus to make the receiver hold off for a long time.
    bit long_hold_due = 1'b0;

    distance_sorted_neighbor_table_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Guard against a hang; the slowest legal run is far shorter than this.
    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic request_t make_req(logic [1:0] op, logic [15:0] addr,
                                          logic [15:0] distance, logic [15:0] snr,
                                          logic [15:0] eff, logic [3:0] position);
        request_t r;
        r          = '0;
        r.op       = op;
        r.addr     = addr;
        r.distance = distance;
        r.snr      = snr;
        r.eff      = eff;
        r.position = position;
        return r;
    endfunction

    // While filling, inserts dominate so the table reaches its full state; while
    // draining, removes dominate so it goes back toward empty. Distances are
    // often drawn from a narrow band so that equal keys are common.
    function automatic request_t random_request(bit filling);
        request_t r;
        int       pick;
        r    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.op = OP_UNUSED;
        else if (pick < 25)
            r.op = OP_READ;
        else if (pick < (filling ? 40 : 75))
            r.op = OP_REMOVE;
        else
            r.op = OP_INSERT;
        if ($urandom_range(0, 99) < 85)
            r.addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
        else
            r.addr = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.distance = 16'(int'($urandom_range(0, 6)) - 3);
        else if (pick < 5)
            r.distance = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        else
            r.distance = 16'($urandom);
        r.snr      = 16'($urandom);
        r.eff      = 16'($urandom);
        r.position = 4'($urandom);
        return r;
    endfunction

    // Offers one request, starting and ending on a falling edge. A gap, when
    // taken, drops tvalid for a burst of cycles before the request goes out.
    task automatic send_req(input request_t r);
        if (traffic_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(r);
        @(negedge clk);
    endtask

    // Result receiver: random stalls, plus one long hold-off so that the
    // output register stays occupied and the block stops taking requests.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (traffic_gaps && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Every result taken by the receiver is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    initial
    begin
        board    = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        for (int k = 0; k < ADDR_POOL; k++)
            addr_pool[k] = 16'($urandom);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. On the empty table, a read, a remove and the unused
        // operation code must all report a miss.
        send_req(make_req(OP_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0));
        send_req(make_req(OP_REMOVE, 16'h1234, 16'h7FFF, 16'h8000, 16'h7FFF, 4'd15));
        send_req(make_req(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15));

        // Fill the table. The first two entries carry the address and distance
        // extremes; the rest repeat a few distances so that new entries must
        // land behind existing ones of equal distance.
        for (int k = 0; k < TABLE_DEPTH_DEF; k++)
        begin
            send_req(make_req(OP_INSERT,
                              (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'(16'h0100 + k),
                              (k == 0) ? 16'h8000 : (k == 1) ? 16'h7FFF : 16'((k % 3) * 7 - 7),
                              k[0] ? 16'h8000 : 16'h7FFF,
                              k[0] ? 16'h7FFF : 16'h8000,
                              4'(k)));
        end

        // A new address on the full table is refused, but an update of an
        // existing one still goes through and moves behind the equal maximum.
        send_req(make_req(OP_INSERT, 16'hBEEF, 16'h0001, 16'h0002, 16'h0003, 4'd0));
        send_req(make_req(OP_INSERT, 16'h0000, 16'h7FFF, 16'h1111, 16'h2222, 4'd0));
        send_req(make_req(OP_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd15));
        send_req(make_req(OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 4'd0));
        // The last position is now past the entry count.
        send_req(make_req(OP_READ, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd15));

        // Random part: alternating fill and drain phases, idle-free stretches
        // in between, one long receiver hold-off, and no gaps at the very end.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            traffic_gaps = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 100) % 4 != 3);
            if (n == HOLD_AT)
                long_hold_due = 1'b1;
            send_req(random_request((n / 120) % 2 == 0));
        end
        s_tvalid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d inserts, %0d updates, %0d remove or read hits.",
                 board.request_count, board.status_seen[STAT_INSERTED],
                 board.status_seen[STAT_UPDATED], board.status_seen[STAT_OK]);
        $display("Also %0d misses and %0d refusals on a full table, with a long output stall.",
                 board.status_seen[STAT_NOT_FOUND], board.status_seen[STAT_FULL]);
        if (board.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
